// ===== rtl/cpu8_pkg.sv =====
package cpu8_pkg;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0, OP_AND = 6'd1, OP_ASL = 6'd2, OP_ASL_ACC = 6'd3, OP_BCC = 6'd4,
        OP_BCS = 6'd5, OP_BEQ = 6'd6, OP_BIT = 6'd7, OP_BMI = 6'd8, OP_BNE = 6'd9,
        OP_BPL = 6'd10, OP_BRK = 6'd11, OP_BVC = 6'd12, OP_BVS = 6'd13, OP_CLC = 6'd14,
        OP_CLD = 6'd15, OP_CLI = 6'd16, OP_CLV = 6'd17, OP_CMP = 6'd18, OP_CPX = 6'd19,
        OP_CPY = 6'd20, OP_DEC = 6'd21, OP_DEX = 6'd22, OP_DEY = 6'd23, OP_EOR = 6'd24,
        OP_INC = 6'd25, OP_INX = 6'd26, OP_INY = 6'd27, OP_JMP = 6'd28, OP_JSR = 6'd29,
        OP_LDA = 6'd30, OP_LDX = 6'd31, OP_LDY = 6'd32, OP_LSR = 6'd33, OP_LSR_ACC = 6'd34,
        OP_NOP = 6'd35, OP_ORA = 6'd36, OP_PHA = 6'd37, OP_PHP = 6'd38, OP_PLA = 6'd39,
        OP_PLP = 6'd40, OP_ROL = 6'd41, OP_ROL_ACC = 6'd42, OP_ROR = 6'd43,
        OP_ROR_ACC = 6'd44, OP_RTI = 6'd45, OP_RTS = 6'd46, OP_SBC = 6'd47, OP_SEC = 6'd48,
        OP_SED = 6'd49, OP_SEI = 6'd50, OP_STA = 6'd51, OP_STX = 6'd52, OP_STY = 6'd53,
        OP_TAX = 6'd54, OP_TAY = 6'd55, OP_TSX = 6'd56, OP_TXA = 6'd57, OP_TXS = 6'd58,
        OP_TYA = 6'd59, OP_RSV60 = 6'd60, OP_RSV61 = 6'd61, OP_RSV62 = 6'd62,
        OP_RSV63 = 6'd63
    } t_op;

    localparam logic [7:0] F_C = 8'h01;
    localparam logic [7:0] F_Z = 8'h02;
    localparam logic [7:0] F_I = 8'h04;
    localparam logic [7:0] F_D = 8'h08;
    localparam logic [7:0] F_B = 8'h10;
    localparam logic [7:0] F_U = 8'h20;
    localparam logic [7:0] F_V = 8'h40;
    localparam logic [7:0] F_N = 8'h80;
    localparam logic [7:0] STACK_PAGE = 8'h01;
    localparam logic [7:0] SP_RESET = 8'hFD;
    localparam logic [7:0] P_RESET = 8'h24;

    typedef struct packed {
        logic [5:0]  opcode;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [15:0] npc;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [7:0]  p3;
        logic [15:0] vec;
    } t_req;

    typedef struct packed {
        logic [1:0]  wr_count;
        logic [2:0][15:0] wr_addr;
        logic [2:0][7:0]  wr_data;
        logic [15:0] pc;
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  p;
        logic        dfault;
    } t_res;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } t_regs;

endpackage

// ===== rtl/eight_bit_cpu_execute_unit_top.sv =====
// Executes one decoded 6502 instruction per request. A request is accepted whenever
// the input register is empty, or in the same cycle that its current request moves
// into the result register. The ALU and the register update are one combinational
// pass between the input register and the result register, which loads the result
// when it is empty or its last result is being taken. Results leave the result
// register one per cycle while i_ready is high. An instruction gives max(1, number
// of memory writes) results, at most three (BRK). With no output stalls,
// single-result instructions run back to back at one request per cycle.
module eight_bit_cpu_execute_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_opcode,
    input  logic [15:0] i_operand_address,
    input  logic [7:0]  i_operand_data,
    input  logic [15:0] i_next_pc,
    input  logic [7:0]  i_pulled_first,
    input  logic [7:0]  i_pulled_second,
    input  logic [7:0]  i_pulled_third,
    input  logic [15:0] i_vector_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_write_valid,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_data,
    output logic [15:0] o_pc_out,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_x_out,
    output logic [7:0]  o_y_out,
    output logic [7:0]  o_sp_out,
    output logic [7:0]  o_status_out,
    output logic        o_decimal_fault,
    output logic        o_last_result
);
    import cpu8_pkg::*;

    t_req  r_req;
    logic  r_req_v;
    t_regs r_regs;
    t_res  n_res, r_res;
    logic  r_res_v;
    logic [1:0] r_idx;
    logic  last, res_take, load;

    cpu8_alu u_alu (.i_req(r_req), .i_regs(r_regs), .o_res(n_res));

    // output sequencing over the writes of one instruction
    assign last     = (r_res.wr_count == 2'd0) || (r_idx == r_res.wr_count - 2'd1);
    assign res_take = r_res_v && i_ready && last;
    assign load     = r_req_v && (!r_res_v || res_take);
    assign o_ready  = !r_req_v || load;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_v <= 1'b0;
        end else if (o_ready) begin
            r_req_v <= i_valid;
        end
        if (o_ready) begin
            r_req <= '{i_opcode, i_operand_address, i_operand_data, i_next_pc,
                       i_pulled_first, i_pulled_second, i_pulled_third, i_vector_word};
        end
    end

    // architectural registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs  <= '{8'd0, 8'd0, 8'd0, SP_RESET, P_RESET};
            r_res_v <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_regs  <= '{n_res.a, n_res.x, n_res.y, n_res.sp, n_res.p};
            r_res_v <= 1'b1;
            r_idx   <= 2'd0;
        end else if (res_take) begin
            r_res_v <= 1'b0;
        end else if (r_res_v && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
        if (load) r_res <= n_res;
    end

    assign o_valid         = r_res_v;
    assign o_write_valid   = (r_res.wr_count != 2'd0);
    assign o_write_address = o_write_valid ? r_res.wr_addr[r_idx] : 16'd0;
    assign o_write_data    = o_write_valid ? r_res.wr_data[r_idx] : 8'd0;
    assign o_pc_out        = r_res.pc;
    assign o_acc_out       = r_res.a;
    assign o_x_out         = r_res.x;
    assign o_y_out         = r_res.y;
    assign o_sp_out        = r_res.sp;
    assign o_status_out    = r_res.p;
    assign o_decimal_fault = r_res.dfault;
    assign o_last_result   = last;
endmodule

// ===== rtl/cpu8_alu.sv =====
module cpu8_alu (
    input  cpu8_pkg::t_req  i_req,
    input  cpu8_pkg::t_regs i_regs,
    output cpu8_pkg::t_res  o_res
);
    import cpu8_pkg::*;

    logic [7:0] a, x, y, sp, p, m, r, cin, sp1, sp2;
    logic [8:0] s;
    logic [15:0] pc, w;
    logic take, br;

    // sum shared by adc and sbc
    assign cin = (i_req.opcode == OP_SBC) ? ~i_req.data : i_req.data;
    assign s   = {1'b0, i_regs.a} + {1'b0, cin} + {8'd0, i_regs.p[0]};
    assign sp1 = i_regs.sp - 8'd1;
    assign sp2 = i_regs.sp - 8'd2;

    always_comb begin
        a = i_regs.a; x = i_regs.x; y = i_regs.y; sp = i_regs.sp; p = i_regs.p;
        m = i_req.data; r = 8'd0; pc = i_req.npc; w = 16'd0;
        take = 1'b0; br = 1'b0;
        o_res = '0;
        unique case (t_op'(i_req.opcode))
            OP_ADC, OP_SBC: begin
                o_res.dfault = i_regs.p[3];
                p[6] = (~(i_regs.a[7] ^ cin[7])) & (i_regs.a[7] ^ s[7]);
                p[0] = s[8];
                a = s[7:0];
                p[7] = a[7]; p[1] = (a == 8'd0);
            end
            OP_AND, OP_EOR, OP_ORA, OP_LDA: begin
                a = (i_req.opcode == OP_AND) ? (a & m) :
                    (i_req.opcode == OP_EOR) ? (a ^ m) :
                    (i_req.opcode == OP_ORA) ? (a | m) : m;
                p[7] = a[7]; p[1] = (a == 8'd0);
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_ASL_ACC, OP_LSR_ACC, OP_ROL_ACC,
            OP_ROR_ACC: begin
                if (i_req.opcode == OP_ASL_ACC || i_req.opcode == OP_LSR_ACC ||
                    i_req.opcode == OP_ROL_ACC || i_req.opcode == OP_ROR_ACC) begin
                    m = i_regs.a;
                end
                if (i_req.opcode == OP_ASL || i_req.opcode == OP_ASL_ACC) begin
                    r = {m[6:0], 1'b0}; p[0] = m[7];
                end else if (i_req.opcode == OP_ROL || i_req.opcode == OP_ROL_ACC) begin
                    r = {m[6:0], i_regs.p[0]}; p[0] = m[7];
                end else if (i_req.opcode == OP_LSR || i_req.opcode == OP_LSR_ACC) begin
                    r = {1'b0, m[7:1]}; p[0] = m[0];
                end else begin
                    r = {i_regs.p[0], m[7:1]}; p[0] = m[0];
                end
                p[7] = r[7]; p[1] = (r == 8'd0);
                if (i_req.opcode == OP_ASL || i_req.opcode == OP_LSR ||
                    i_req.opcode == OP_ROL || i_req.opcode == OP_ROR) begin
                    o_res.wr_count = 2'd1; o_res.wr_addr[0] = i_req.addr;
                    o_res.wr_data[0] = r;
                end else begin
                    a = r;
                end
            end
            OP_BCC: begin br = 1'b1; take = ~i_regs.p[0]; end
            OP_BCS: begin br = 1'b1; take = i_regs.p[0]; end
            OP_BEQ: begin br = 1'b1; take = i_regs.p[1]; end
            OP_BNE: begin br = 1'b1; take = ~i_regs.p[1]; end
            OP_BMI: begin br = 1'b1; take = i_regs.p[7]; end
            OP_BPL: begin br = 1'b1; take = ~i_regs.p[7]; end
            OP_BVC: begin br = 1'b1; take = ~i_regs.p[6]; end
            OP_BVS: begin br = 1'b1; take = i_regs.p[6]; end
            OP_BIT: begin
                p[7] = m[7]; p[6] = m[6]; p[1] = ((m & i_regs.a) == 8'd0);
            end
            OP_BRK: begin
                w = i_req.npc + 16'd1;
                o_res.wr_count = 2'd3;
                o_res.wr_addr[0] = {STACK_PAGE, i_regs.sp};
                o_res.wr_addr[1] = {STACK_PAGE, sp1};
                o_res.wr_addr[2] = {STACK_PAGE, sp2};
                o_res.wr_data[0] = w[15:8];
                o_res.wr_data[1] = w[7:0];
                o_res.wr_data[2] = i_regs.p | F_B | F_U;
                sp = i_regs.sp - 8'd3;
                p = i_regs.p | F_I;
                pc = i_req.vec;
            end
            OP_JSR: begin
                w = i_req.npc - 16'd1;
                o_res.wr_count = 2'd2;
                o_res.wr_addr[0] = {STACK_PAGE, i_regs.sp};
                o_res.wr_addr[1] = {STACK_PAGE, sp1};
                o_res.wr_data[0] = w[15:8];
                o_res.wr_data[1] = w[7:0];
                sp = sp2;
                pc = i_req.addr;
            end
            OP_CLC: p = p & ~F_C;
            OP_CLD: p = p & ~F_D;
            OP_CLI: p = p & ~F_I;
            OP_CLV: p = p & ~F_V;
            OP_SEC: p = p | F_C;
            OP_SED: p = p | F_D;
            OP_SEI: p = p | F_I;
            OP_CMP, OP_CPX, OP_CPY: begin
                r = (i_req.opcode == OP_CMP) ? i_regs.a :
                    (i_req.opcode == OP_CPX) ? i_regs.x : i_regs.y;
                p[0] = (r >= m);
                r = r - m;
                p[7] = r[7]; p[1] = (r == 8'd0);
            end
            OP_DEC, OP_INC: begin
                r = (i_req.opcode == OP_DEC) ? (m - 8'd1) : (m + 8'd1);
                p[7] = r[7]; p[1] = (r == 8'd0);
                o_res.wr_count = 2'd1; o_res.wr_addr[0] = i_req.addr;
                o_res.wr_data[0] = r;
            end
            OP_DEX, OP_INX, OP_LDX, OP_TAX, OP_TSX: begin
                x = (i_req.opcode == OP_DEX) ? (x - 8'd1) :
                    (i_req.opcode == OP_INX) ? (x + 8'd1) :
                    (i_req.opcode == OP_LDX) ? m :
                    (i_req.opcode == OP_TAX) ? i_regs.a : i_regs.sp;
                p[7] = x[7]; p[1] = (x == 8'd0);
            end
            OP_DEY, OP_INY, OP_LDY, OP_TAY: begin
                y = (i_req.opcode == OP_DEY) ? (y - 8'd1) :
                    (i_req.opcode == OP_INY) ? (y + 8'd1) :
                    (i_req.opcode == OP_LDY) ? m : i_regs.a;
                p[7] = y[7]; p[1] = (y == 8'd0);
            end
            OP_TXA, OP_TYA, OP_PLA: begin
                a = (i_req.opcode == OP_TXA) ? i_regs.x :
                    (i_req.opcode == OP_TYA) ? i_regs.y : i_req.p1;
                if (i_req.opcode == OP_PLA) sp = i_regs.sp + 8'd1;
                p[7] = a[7]; p[1] = (a == 8'd0);
            end
            OP_TXS: sp = i_regs.x;
            OP_JMP: pc = i_req.addr;
            OP_PHA, OP_PHP: begin
                o_res.wr_count = 2'd1;
                o_res.wr_addr[0] = {STACK_PAGE, i_regs.sp};
                o_res.wr_data[0] = (i_req.opcode == OP_PHA) ? i_regs.a :
                                   (i_regs.p | F_B | F_U);
                sp = sp1;
            end
            OP_PLP: begin
                sp = i_regs.sp + 8'd1;
                p = (i_req.p1 | F_U) & ~F_B;
            end
            OP_RTI: begin
                sp = i_regs.sp + 8'd3;
                p = (i_req.p1 | F_U) & ~F_B;
                pc = {i_req.p3, i_req.p2};
            end
            OP_RTS: begin
                sp = i_regs.sp + 8'd2;
                pc = {i_req.p2, i_req.p1} + 16'd1;
            end
            OP_STA, OP_STX, OP_STY: begin
                o_res.wr_count = 2'd1; o_res.wr_addr[0] = i_req.addr;
                o_res.wr_data[0] = (i_req.opcode == OP_STA) ? i_regs.a :
                                   (i_req.opcode == OP_STX) ? i_regs.x : i_regs.y;
            end
            default: ;
        endcase
        if (br && take) pc = i_req.addr;
        o_res.pc = pc; o_res.a = a; o_res.x = x; o_res.y = y;
        o_res.sp = sp; o_res.p = p;
    end
endmodule
